@@ src/tmcw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared types and constants of the text-mode console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CODE_NL  = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_CR  = 8'd13;
    localparam logic [CHAR_W-1:0] CODE_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CODE_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] BLANK    = 8'h20;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
    localparam int                TAB_STEP   = 4;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // take the item on the input ports
        logic sweep;     // write a blank cell at the sweep counter, advance
        logic rst_attr;  // sweep with the reset attribute
        logic copy;      // copy the cell one row below into the counter cell
        logic emit;      // register the result word
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scroll;     // a write at the cursor would leave the last row
        logic cnt_last;   // sweep counter on the last cell
        logic copy_last;  // sweep counter on the last cell that takes a copy
    } t_dp_sts;

endpackage

@@ src/text_mode_console_writer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_console_writer_unit
// Character-cell text console with cursor, control codes and scrolling.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand over one word (op, char_code,
// read_row, read_col). Every word yields exactly one result word, shown for
// a single cycle while o_strobe is high; the receiver cannot stall it, so
// capture it on that cycle. For a write, read or unused op the word goes
// through the state register and then the strobe register, and a new word
// can be started in the cycle the strobe is shown. A clear, and a write that
// runs off the last row and scrolls, walk the whole screen store at one cell
// per cycle through its single write port. After reset busy stays high while
// the store is cleared to spaces with attribute 7. Write the attribute
// register only while no word is in flight; it may be written during the
// reset clearing pass.
// ----------------------------------------------------------------------------
module text_mode_console_writer_unit
    import tmcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    localparam int CW     = $clog2(COLUMNS),
    localparam int RW     = $clog2(ROWS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command channel
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_op,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [RW-1:0]     i_read_row,
    input  logic [CW-1:0]     i_read_col,
    // attribute register
    input  logic              i_cfg_we,
    input  logic [ATTR_W-1:0] i_cfg_wdata,
    // result channel
    output logic              o_strobe,
    output logic [CW-1:0]     o_cursor_col,
    output logic [RW-1:0]     o_cursor_row,
    output logic [CHAR_W-1:0] o_cell_char,
    output logic [ATTR_W-1:0] o_cell_attr
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: reset clear pass, dispatch, clear/scroll sweeps, result
    tmcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // cursor logic, screen store and result register
    tmcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (i_op),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_strobe     (o_strobe),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr)
    );

endmodule

@@ src/tmcw_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_ctrl
// Sequencer of the console writer: clearing pass, item dispatch, sweeps.
// ----------------------------------------------------------------------------
module tmcw_ctrl
    import tmcw_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [OP_W-1:0] i_op,
    input  t_dp_sts         i_sts,
    output t_dp_cmd         o_cmd,
    output logic            o_busy
);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CLEAR = 3'd2;
    localparam logic [2:0] S_COPY  = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.sweep    = 1'b1;
                o_cmd.rst_attr = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    priority if (i_op == OP_WRITE && i_sts.scroll) begin
                        n_state = S_COPY;
                    end else if (i_op == OP_CLEAR) begin
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_DONE;
                end
            end
            S_COPY: begin
                o_cmd.copy = 1'b1;
                if (i_sts.copy_last) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ src/tmcw_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_dp
// Datapath: cursor, attribute register, screen store, sweep counter, result.
// ----------------------------------------------------------------------------
module tmcw_dp
    import tmcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    localparam int CW     = $clog2(COLUMNS),
    localparam int RW     = $clog2(ROWS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [OP_W-1:0]   i_op,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [RW-1:0]     i_read_row,
    input  logic [CW-1:0]     i_read_col,
    input  logic              i_cfg_we,
    input  logic [ATTR_W-1:0] i_cfg_wdata,
    output logic              o_strobe,
    output logic [CW-1:0]     o_cursor_col,
    output logic [RW-1:0]     o_cursor_row,
    output logic [CHAR_W-1:0] o_cell_char,
    output logic [ATTR_W-1:0] o_cell_attr
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int DW    = CHAR_W + ATTR_W;

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_LAST = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] ROW_SPAN  = AW'(COLUMNS);
    localparam logic [CW:0]   COL_LIM   = (CW + 1)'(COLUMNS);
    localparam logic [RW:0]   ROW_LIM   = (RW + 1)'(ROWS);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

    logic [DW-1:0]     mem [CELLS];
    logic [DW-1:0]     r_rdata;
    logic [ATTR_W-1:0] r_attr;
    logic [CW-1:0]     r_cur_x;
    logic [RW-1:0]     r_cur_y;
    logic [AW-1:0]     r_cnt;
    logic              r_we;
    logic [AW-1:0]     r_wa;
    logic [DW-1:0]     r_wd;
    logic              r_wcopy;
    logic              r_is_read;
    logic              r_strobe;
    logic [CW-1:0]     r_out_col;
    logic [RW-1:0]     r_out_row;
    logic [CHAR_W-1:0] r_out_char;
    logic [ATTR_W-1:0] r_out_attr;

    logic [CW-1:0] n_x;
    logic [RW-1:0] n_y;
    logic [CW:0]   x_inc;
    logic [CW:0]   x_tab;
    logic          wrap_row;
    logic          store;
    logic          rd_ok;
    logic [AW-1:0] cur_pos;
    logic [AW-1:0] rd_pos;
    logic [AW-1:0] mem_ra;
    logic          do_write;
    logic [DW-1:0] wr_data;

    // next cursor for a write item
    always_comb begin
        x_inc    = {1'b0, r_cur_x} + (CW + 1)'(1);
        x_tab    = {1'b0, r_cur_x[CW-1:2], 2'b00} + (CW + 1)'(TAB_STEP);
        n_x      = r_cur_x;
        n_y      = r_cur_y;
        wrap_row = 1'b0;
        store    = 1'b0;
        unique case (i_char_code)
            CODE_NL: begin
                wrap_row = 1'b1;
            end
            CODE_CR: begin
                n_x = '0;
            end
            CODE_TAB: begin
                if (x_tab >= COL_LIM) begin
                    wrap_row = 1'b1;
                end else begin
                    n_x = x_tab[CW-1:0];
                end
            end
            CODE_BS: begin
                if (r_cur_x != '0) begin
                    n_x = r_cur_x - CW'(1);
                end else if (r_cur_y != '0) begin
                    n_x = LAST_COL;
                    n_y = r_cur_y - RW'(1);
                end
            end
            default: begin
                store = 1'b1;
                if (x_inc >= COL_LIM) begin
                    wrap_row = 1'b1;
                end else begin
                    n_x = x_inc[CW-1:0];
                end
            end
        endcase
        // stay on the last row; the scroll moves the text instead
        if (wrap_row) begin
            n_x = '0;
            if (r_cur_y != LAST_ROW) begin
                n_y = r_cur_y + RW'(1);
            end
        end
    end

    assign o_sts.scroll    = wrap_row && (r_cur_y == LAST_ROW);
    assign o_sts.cnt_last  = (r_cnt == LAST_CELL);
    assign o_sts.copy_last = (r_cnt == COPY_LAST);

    assign cur_pos  = AW'(r_cur_x) + AW'(r_cur_y) * ROW_SPAN;
    assign rd_ok    = ({1'b0, i_read_row} < ROW_LIM) && ({1'b0, i_read_col} < COL_LIM);
    assign rd_pos   = rd_ok ? AW'(i_read_col) + AW'(i_read_row) * ROW_SPAN : '0;
    assign mem_ra   = i_cmd.copy ? r_cnt + ROW_SPAN : rd_pos;
    assign do_write = i_cmd.accept && (i_op == OP_WRITE) && store;
    assign wr_data  = r_wcopy ? r_rdata : r_wd;

    // screen store: one write, one registered read per cycle; a read of the
    // cell being written in the same cycle takes the new data
    always_ff @(posedge i_clk) begin
        if (r_we) begin
            mem[r_wa] <= wr_data;
        end
        r_rdata <= (r_we && r_wa == mem_ra) ? wr_data : mem[mem_ra];
    end

    // write stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_we <= 1'b0;
        end else begin
            r_we <= do_write || i_cmd.sweep || i_cmd.copy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_wa    <= cur_pos;
            r_wd    <= {i_char_code, r_attr};
            r_wcopy <= 1'b0;
        end else if (i_cmd.sweep) begin
            r_wa    <= r_cnt;
            r_wd    <= {BLANK, (i_cmd.rst_attr ? RESET_ATTR : r_attr)};
            r_wcopy <= 1'b0;
        end else if (i_cmd.copy) begin
            r_wa    <= r_cnt;
            r_wcopy <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr    <= RESET_ATTR;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_cnt     <= '0;
            r_is_read <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
            if (i_cmd.accept && i_op == OP_WRITE) begin
                r_cur_x <= n_x;
                r_cur_y <= n_y;
            end
            if (i_cmd.accept) begin
                r_is_read <= (i_op == OP_READ) && rd_ok;
            end
            // wrap to zero at the end of a full sweep
            if (i_cmd.sweep || i_cmd.copy) begin
                r_cnt <= (r_cnt == LAST_CELL) ? '0 : r_cnt + AW'(1);
            end
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_col  <= r_cur_x;
            r_out_row  <= r_cur_y;
            r_out_char <= r_is_read ? r_rdata[DW-1:ATTR_W] : '0;
            r_out_attr <= r_is_read ? r_rdata[ATTR_W-1:0] : '0;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_cell_char  = r_out_char;
    assign o_cell_attr  = r_out_attr;

endmodule

@@ tb/text_mode_console_writer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_console_writer_unit_tb
// Self-checking bench for the text-mode console writer at 80x25.
// ----------------------------------------------------------------------------
// A local screen model tracks the cursor, the attribute register and every
// cell. Each word accepted on the command channel is run through the model,
// and the expected result word is queued. Each strobed result word is checked
// field by field against the oldest queued one. Directed tests cover reset
// contents, every control code and its corner cases, out-of-range reads, the
// unused op and clear. Random traffic then runs in phases under different
// attribute settings, with mostly well-formed text plus reads around the
// cursor, so that lines wrap, the screen scrolls and moved rows are read back.
// ----------------------------------------------------------------------------
module text_mode_console_writer_unit_tb;
    import tmcw_pkg::*;

    localparam int COLS       = 80;
    localparam int LINES      = 25;
    localparam int CELL_COUNT = COLS * LINES;
    // Longest quiet stretch of a correct run is a scroll or clear walk plus a
    // sender gap; allow several times that.
    localparam int IDLE_LIMIT = 12000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [6:0] col;
        logic [4:0] row;
        logic [7:0] ch;
        logic [7:0] at;
    } t_console_result;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   i_op;
    logic [CHAR_W-1:0] i_char_code;
    logic [4:0]        i_read_row;
    logic [6:0]        i_read_col;
    logic              i_cfg_we;
    logic [ATTR_W-1:0] i_cfg_wdata;
    logic              o_strobe;
    logic [6:0]        o_cursor_col;
    logic [4:0]        o_cursor_row;
    logic [CHAR_W-1:0] o_cell_char;
    logic [ATTR_W-1:0] o_cell_attr;

    text_mode_console_writer_unit #(
        .COLUMNS (COLS),
        .ROWS    (LINES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_strobe     (o_strobe),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr)
    );

    // ------------------------------------------------------------------------
    // Clock: 2 ns period
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Screen model state
    // ------------------------------------------------------------------------
    logic [7:0] screen_char [CELL_COUNT];
    logic [7:0] screen_attr [CELL_COUNT];
    int         cur_col;
    int         cur_row;
    logic [7:0] model_attr;

    t_console_result pending_results [$];
    t_console_result want_word;

    int  error_count;
    int  word_count;
    int  read_count;
    int  clear_count;
    int  scroll_count;
    int  attr_writes;
    int  idle_cycles;
    bit  no_idle;

    // Start a new line; scroll everything up one row when leaving the last.
    function automatic void advance_line();
        cur_col = 0;
        cur_row++;
        if (cur_row >= LINES) begin
            for (int i = 0; i + COLS < CELL_COUNT; i++) begin
                screen_char[i] = screen_char[i + COLS];
                screen_attr[i] = screen_attr[i + COLS];
            end
            for (int i = CELL_COUNT - COLS; i < CELL_COUNT; i++) begin
                screen_char[i] = BLANK;
                screen_attr[i] = model_attr;
            end
            cur_row = LINES - 1;
            scroll_count++;
        end
    endfunction

    // Apply one word to the screen model and return the result word it yields.
    function automatic t_console_result predict_console_word(
        input logic [OP_W-1:0]   op,
        input logic [CHAR_W-1:0] ch,
        input logic [4:0]        rr,
        input logic [6:0]        rc
    );
        t_console_result res;
        int pos;
        res = '0;
        case (op)
            OP_WRITE: begin
                if (ch == CODE_NL) begin
                    advance_line();
                end else if (ch == CODE_CR) begin
                    cur_col = 0;
                end else if (ch == CODE_TAB) begin
                    cur_col += TAB_STEP - (cur_col % TAB_STEP);
                    if (cur_col >= COLS) advance_line();
                end else if (ch == CODE_BS) begin
                    if (cur_col > 0) begin
                        cur_col--;
                    end else if (cur_row > 0) begin
                        cur_row--;
                        cur_col = COLS - 1;
                    end
                end else begin
                    pos = cur_col + COLS * cur_row;
                    screen_char[pos] = ch;
                    screen_attr[pos] = model_attr;
                    cur_col++;
                    if (cur_col >= COLS) advance_line();
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELL_COUNT; i++) begin
                    screen_char[i] = BLANK;
                    screen_attr[i] = model_attr;
                end
                clear_count++;
            end
            OP_READ: begin
                read_count++;
                if (rr < LINES && rc < COLS) begin
                    pos = rc + COLS * rr;
                    res.ch = screen_char[pos];
                    res.at = screen_attr[pos];
                end
            end
            default: ;
        endcase
        res.col = cur_col[6:0];
        res.row = cur_row[4:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Command channel: hand over one word. Start is left high on return so a
    // back-to-back word does not drop it; park_sender lowers it.
    // ------------------------------------------------------------------------
    task automatic send_word(
        input logic [OP_W-1:0]   op,
        input logic [CHAR_W-1:0] ch,
        input logic [4:0]        rr,
        input logic [6:0]        rc
    );
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_op        <= op;
        i_char_code <= ch;
        i_read_row  <= rr;
        i_read_col  <= rc;
        // Hold the word until an edge sees busy low.
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(predict_console_word(op, ch, rr, rc));
        word_count++;
    endtask

    task automatic park_sender();
        start <= 1'b0;
    endtask

    // Drop start and wait until every queued result word has come back.
    task automatic drain_results();
        park_sender();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Write the attribute register; only called with nothing in flight.
    task automatic set_text_attr(input logic [ATTR_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        model_attr = value;
        attr_writes++;
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result checker: compare each strobed word with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word col=%0d row=%0d char=%02h attr=%02h",
                         $time, o_cursor_col, o_cursor_row, o_cell_char, o_cell_attr);
                error_count++;
            end else begin
                want_word = pending_results.pop_front();
                if (o_cursor_col !== want_word.col) begin
                    $display("%0t: cursor_col expected %0d actual %0d",
                             $time, want_word.col, o_cursor_col);
                    error_count++;
                end
                if (o_cursor_row !== want_word.row) begin
                    $display("%0t: cursor_row expected %0d actual %0d",
                             $time, want_word.row, o_cursor_row);
                    error_count++;
                end
                if (o_cell_char !== want_word.ch) begin
                    $display("%0t: cell_char expected %02h actual %02h",
                             $time, want_word.ch, o_cell_char);
                    error_count++;
                end
                if (o_cell_attr !== want_word.at) begin
                    $display("%0t: cell_attr expected %02h actual %02h",
                             $time, want_word.at, o_cell_attr);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count edges with neither an accepted word nor a result word
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("text_mode_console_writer_unit_tb failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Read the corner cells straight after reset: spaces with attribute 7.
    task automatic test_reset_contents();
        send_word(OP_READ, 8'h00, 5'd0, 7'd0);
        send_word(OP_READ, 8'hFF, 5'(LINES - 1), 7'(COLS - 1));
    endtask

    // Walk every control code through its corner cases from the top-left.
    task automatic test_control_codes();
        send_word(OP_WRITE, CODE_BS, 5'd0, 7'd0);   // backspace at the corner
        send_word(OP_WRITE, 8'h00, 5'd0, 7'd0);     // lowest byte is stored
        send_word(OP_WRITE, 8'hFF, 5'd0, 7'd0);     // highest byte is stored
        send_word(OP_WRITE, CODE_TAB, 5'd0, 7'd0);
        send_word(OP_WRITE, "A", 5'd0, 7'd0);
        send_word(OP_WRITE, CODE_CR, 5'd0, 7'd0);
        send_word(OP_WRITE, CODE_NL, 5'd0, 7'd0);
        send_word(OP_WRITE, CODE_BS, 5'd0, 7'd0);   // wrap to end of row above
        send_word(OP_WRITE, "Z", 5'd0, 7'd0);       // last column, then wrap
        send_word(OP_READ, 8'h00, 5'd0, 7'd0);
        send_word(OP_READ, 8'h00, 5'd0, 7'd1);
        send_word(OP_READ, 8'h00, 5'd0, 7'(COLS - 1));
    endtask

    // Out-of-range reads return zero; the unused op changes nothing.
    task automatic test_read_bounds();
        send_word(OP_READ, 8'h00, 5'(LINES), 7'd0);
        send_word(OP_READ, 8'h00, 5'd0, 7'(COLS));
        send_word(OP_READ, 8'h00, 5'h1F, 7'h7F);
        send_word(OP_UNUSED, 8'hFF, 5'h1F, 7'h7F);
    endtask

    // Clear under the top attribute, store under the bottom one.
    task automatic test_clear_screen();
        set_text_attr(8'hFF);
        send_word(OP_CLEAR, 8'h00, 5'd0, 7'd0);
        send_word(OP_READ, 8'h00, 5'd0, 7'(COLS - 1));
        set_text_attr(8'h00);
        send_word(OP_WRITE, "q", 5'd0, 7'd0);
        send_word(OP_READ, 8'h00, cur_row[4:0], 7'd0);
        send_word(OP_READ, 8'h00, 5'(LINES - 1), 7'd0);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------------

    // Draw one word: mostly text, reads around the cursor, some noise.
    task automatic send_random_word();
        int         pick;
        int         sel;
        logic [7:0] ch;
        int         rr;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                ch = 8'($urandom_range(32, 126));
            end else if (sel < 80) begin
                ch = 8'($urandom_range(0, 255));
            end else if (sel < 88) begin
                ch = CODE_NL;
            end else if (sel < 94) begin
                ch = CODE_TAB;
            end else if (sel < 97) begin
                ch = CODE_CR;
            end else begin
                ch = CODE_BS;
            end
            send_word(OP_WRITE, ch, 5'($urandom_range(0, 31)),
                      7'($urandom_range(0, 127)));
        end else if (pick < 80) begin
            // Aim at the cursor row or the one above, where text just landed.
            if ($urandom_range(0, 1) == 0) begin
                rr = cur_row - $urandom_range(0, 1);
                if (rr < 0) rr = 0;
            end else begin
                rr = $urandom_range(0, LINES - 1);
            end
            send_word(OP_READ, 8'($urandom_range(0, 255)), rr[4:0],
                      7'($urandom_range(0, COLS - 1)));
        end else if (pick < 86) begin
            send_word(OP_READ, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                      7'($urandom_range(0, 127)));
        end else if (pick < 88) begin
            send_word(OP_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                      7'($urandom_range(0, 127)));
        end else if (pick < 91) begin
            send_word(OP_UNUSED, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                      7'($urandom_range(0, 127)));
        end else begin
            // Burst of plain text so rows fill and wrap.
            repeat ($urandom_range(5, 40)) begin
                send_word(OP_WRITE, 8'($urandom_range(32, 126)),
                          5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
            end
        end
    endtask

    // Phases under changing attributes, the extremes among them.
    task automatic test_random_traffic();
        logic [7:0] phase_attr;
        int         phase_start;
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0:       phase_attr = 8'h00;
                1:       phase_attr = 8'hFF;
                2:       phase_attr = RESET_ATTR;
                default: phase_attr = 8'($urandom_range(0, 255));
            endcase
            set_text_attr(phase_attr);
            // Every third phase runs with the sender never idling.
            no_idle = (phase % 3 == 2);
            phase_start = word_count;
            while (word_count - phase_start < 110) send_random_word();
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_op        <= OP_WRITE;
        i_char_code <= '0;
        i_read_row  <= '0;
        i_read_col  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        error_count  = 0;
        word_count   = 0;
        read_count   = 0;
        clear_count  = 0;
        scroll_count = 0;
        attr_writes  = 0;
        idle_cycles  = 0;
        no_idle      = 1'b0;
        cur_col      = 0;
        cur_row      = 0;
        model_attr   = RESET_ATTR;
        for (int i = 0; i < CELL_COUNT; i++) begin
            screen_char[i] = BLANK;
            screen_attr[i] = RESET_ATTR;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_contents();
        test_control_codes();
        test_read_bounds();
        test_clear_screen();
        test_random_traffic();

        // Wait for the last result word, then let the pipe settle.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words: %0d reads, %0d clears, %0d scrolls",
                 word_count, read_count, clear_count, scroll_count);
        $display("Attribute register written %0d times, extremes included", attr_writes);
        if (error_count == 0) begin
            $display("text_mode_console_writer_unit_tb passed");
        end else begin
            $display("text_mode_console_writer_unit_tb failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/tmcw_pkg.sv
src/tmcw_ctrl.sv
src/tmcw_dp.sv
src/text_mode_console_writer_unit.sv
tb/text_mode_console_writer_unit_tb.sv
